// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the slot pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising aclk outside reset.
`define ASSERT_HOLDS(label, cond, chk) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (chk)) \
        else $error("assertion failed in %m");

// Next-cycle implication, checked on every rising aclk outside reset.
`define ASSERT_NEXT(label, cond, chk) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (chk)) \
        else $error("assertion failed in %m");

`endif

// ----- src/fspa_pkg.sv -----
// Types, constants and helper functions of the fixed slot pool allocator.
`timescale 1ns / 1ps

package fspa_pkg;

    localparam int POOL_SLOTS  = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int OBJ_W       = 13;
    localparam int ALIGN_W     = 4;
    localparam int REQ_W       = 16;
    localparam int OFS_W       = 23;
    localparam int USED_W      = 23;
    localparam int OBJ_MIN     = 8;
    localparam int OBJ_MAX     = 4096;
    localparam int ALIGN_MAX   = 12;
    // Queue depth must be a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    // Full widths of the offset and used-bytes products.
    localparam int PROD_OFS_W  = IDX_W + OBJ_W;
    localparam int PROD_USED_W = CNT_W + OBJ_W;

    typedef enum logic [1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_FREE       = 2'd1,
        CMD_POOL_RESET = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_BACKING    = 2'd2,
        ST_RESET_DONE = 2'd3
    } status_t;

    typedef enum logic {
        BK_EXEC,
        BK_LINK
    } back_state_t;

    // Effective configuration seen by the front and back parts.
    typedef struct packed {
        logic [OBJ_W-1:0]   obj_bytes;
        logic [ALIGN_W-1:0] align_log2;
        logic [OBJ_W-1:0]   slot_bytes;
    } cfg_t;

    // Classified request carried through the queue.
    typedef struct packed {
        cmd_t             cmd;
        logic             reject;
        logic [IDX_W-1:0] slot;
    } op_t;

    function automatic logic [OBJ_W-1:0] eff_object(input logic [OBJ_W-1:0] b);
        logic [OBJ_W-1:0] r;
        r = b;
        if (b < OBJ_W'(OBJ_MIN)) r = OBJ_W'(OBJ_MIN);
        else if (b > OBJ_W'(OBJ_MAX)) r = OBJ_W'(OBJ_MAX);
        return r;
    endfunction

    function automatic logic [ALIGN_W-1:0] eff_align(input logic [ALIGN_W-1:0] a);
        logic [ALIGN_W-1:0] r;
        r = (a > ALIGN_W'(ALIGN_MAX)) ? ALIGN_W'(ALIGN_MAX) : a;
        return r;
    endfunction

    // Object size rounded up to the slot alignment; never exceeds 4096.
    function automatic logic [OBJ_W-1:0] aligned_size(input logic [OBJ_W-1:0]   obj,
                                                      input logic [ALIGN_W-1:0] al);
        logic [OBJ_W-1:0] mask;
        mask = (OBJ_W'(1) << al) - OBJ_W'(1);
        return (obj + mask) & ~mask;
    endfunction

endpackage

// ----- src/fspa_front.sv -----
// Front part: takes requests, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module fspa_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fspa_pkg::cfg_t       cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // req_bytes, req_align_log2, free_slot, zero pad
    input  logic [1:0]           s_tuser,   // cmd
    output logic                 push_valid,
    input  logic                 push_ready,
    output fspa_pkg::op_t        push_op
);

    logic [fspa_pkg::REQ_W-1:0]   req_bytes;
    logic [fspa_pkg::ALIGN_W-1:0] req_align;
    logic [fspa_pkg::IDX_W-1:0]   req_slot;
    logic                         over_bytes;
    logic                         over_align;
    logic                         bad_slot;
    fspa_pkg::op_t                op_next;
    fspa_pkg::op_t                op_reg;
    logic                         valid_reg;

    assign req_bytes = s_tdata[15:0];
    assign req_align = s_tdata[19:16];
    assign req_slot  = s_tdata[29:20];

    assign over_bytes = req_bytes > fspa_pkg::REQ_W'(cfg.obj_bytes);
    assign over_align = req_align > cfg.align_log2;
    assign bad_slot   = fspa_pkg::CNT_W'(req_slot) >= fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS);

    always_comb begin
        op_next.cmd  = fspa_pkg::cmd_t'(s_tuser);
        op_next.slot = req_slot;
        case (op_next.cmd)
            fspa_pkg::CMD_ALLOC: op_next.reject = over_bytes | over_align;
            fspa_pkg::CMD_FREE:  op_next.reject = over_bytes | bad_slot;
            default:             op_next.reject = 1'b0;
        endcase
    end

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_op    = op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= op_next;
        end
    end

endmodule

// ----- src/fspa_queue.sv -----
// Short request queue between the front and back parts.
`timescale 1ns / 1ps

module fspa_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  fspa_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output fspa_pkg::op_t pop_op
);

    fspa_pkg::op_t               entry_reg [fspa_pkg::QUEUE_DEPTH];
    logic [fspa_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fspa_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fspa_pkg::QPTR_W:0]   count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = count_reg != (fspa_pkg::QPTR_W + 1)'(fspa_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- src/fspa_back.sv -----
// Back part: free-list state, link memory, result and product stages.
`timescale 1ns / 1ps

module fspa_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  fspa_pkg::cfg_t cfg,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  fspa_pkg::op_t  pop_op,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [71:0]    m_tdata,   // slot_index, slot_offset, free_cnt, used_bytes, pad
    output logic [1:0]     m_tuser    // status
);

    fspa_pkg::back_state_t       state_reg, state_next;
    logic [fspa_pkg::IDX_W-1:0]  head_reg, head_next;
    logic                        nonempty_reg, nonempty_next;
    logic [fspa_pkg::CNT_W-1:0]  fresh_reg, fresh_next;
    logic [fspa_pkg::CNT_W-1:0]  free_reg, free_next;
    logic [fspa_pkg::CNT_W-1:0]  fresh_dec;
    logic [fspa_pkg::CNT_W-1:0]  free_dec;
    fspa_pkg::status_t           status_next;
    logic [fspa_pkg::IDX_W-1:0]  index_next;

    logic [fspa_pkg::IDX_W-1:0]  link_mem [fspa_pkg::POOL_SLOTS];
    logic [fspa_pkg::IDX_W-1:0]  link_q_reg;
    logic [fspa_pkg::IDX_W-1:0]  link_wdata;
    logic                        link_rd;
    logic                        link_wr;

    logic                        exec;
    logic                        res_move;
    logic                        res_valid_reg;
    fspa_pkg::status_t           res_status_reg;
    logic [fspa_pkg::IDX_W-1:0]  res_index_reg;
    logic [fspa_pkg::CNT_W-1:0]  res_free_reg;

    logic [fspa_pkg::CNT_W-1:0]       used_cnt;
    logic [fspa_pkg::PROD_OFS_W-1:0]  offset_prod;
    logic [fspa_pkg::PROD_USED_W-1:0] used_prod;

    logic                        out_valid_reg;
    fspa_pkg::status_t           out_status_reg;
    logic [fspa_pkg::IDX_W-1:0]  out_index_reg;
    logic [fspa_pkg::OFS_W-1:0]  out_offset_reg;
    logic [fspa_pkg::CNT_W-1:0]  out_free_reg;
    logic [fspa_pkg::USED_W-1:0] out_used_reg;

    assign res_move  = res_valid_reg && (!out_valid_reg || m_tready);
    assign pop_ready = (state_reg == fspa_pkg::BK_EXEC) && (!res_valid_reg || res_move);
    assign exec      = pop_valid && pop_ready;

    assign fresh_dec  = fresh_reg - 1'b1;
    assign free_dec   = free_reg - 1'b1;
    assign link_wdata = nonempty_reg ? head_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fspa_pkg::BK_EXEC;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS);
            free_reg     <= fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS);
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            fresh_reg    <= fresh_next;
            free_reg     <= free_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        fresh_next    = fresh_reg;
        free_next     = free_reg;
        status_next   = fspa_pkg::ST_OK;
        index_next    = '0;
        link_rd       = 1'b0;
        link_wr       = 1'b0;
        case (state_reg)
            fspa_pkg::BK_EXEC: begin
                if (exec) begin
                    case (pop_op.cmd)
                        fspa_pkg::CMD_ALLOC: begin
                            if (pop_op.reject) begin
                                status_next = fspa_pkg::ST_BACKING;
                            end else if (nonempty_reg) begin
                                // Pop the freed stack; the new head arrives from the link memory.
                                index_next    = head_reg;
                                free_next     = free_dec;
                                nonempty_next = free_dec > fresh_reg;
                                link_rd       = 1'b1;
                                state_next    = fspa_pkg::BK_LINK;
                            end else if (fresh_reg != '0) begin
                                fresh_next = fresh_dec;
                                free_next  = free_dec;
                                index_next = fresh_dec[fspa_pkg::IDX_W-1:0];
                            end else begin
                                status_next = fspa_pkg::ST_EMPTY;
                            end
                        end
                        fspa_pkg::CMD_FREE: begin
                            if (pop_op.reject) begin
                                status_next = fspa_pkg::ST_BACKING;
                            end else if (free_reg < fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS)) begin
                                link_wr       = 1'b1;
                                head_next     = pop_op.slot;
                                nonempty_next = 1'b1;
                                free_next     = free_reg + 1'b1;
                            end
                        end
                        fspa_pkg::CMD_POOL_RESET: begin
                            head_next     = '0;
                            nonempty_next = 1'b0;
                            fresh_next    = fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS);
                            free_next     = fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS);
                            status_next   = fspa_pkg::ST_RESET_DONE;
                        end
                        default: begin
                            status_next = fspa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            fspa_pkg::BK_LINK: begin
                head_next  = link_q_reg;
                state_next = fspa_pkg::BK_EXEC;
            end
            default: begin
                state_next = fspa_pkg::BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (link_wr) begin
            link_mem[pop_op.slot] <= link_wdata;
        end
        if (link_rd) begin
            link_q_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (exec) begin
            res_valid_reg <= 1'b1;
        end else if (res_move) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            res_status_reg <= status_next;
            res_index_reg  <= index_next;
            res_free_reg   <= free_next;
        end
    end

    // A refused or non-granting request carries index zero, so its offset is zero too.
    assign used_cnt    = fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS) - res_free_reg;
    assign offset_prod = fspa_pkg::PROD_OFS_W'(res_index_reg)
                       * fspa_pkg::PROD_OFS_W'(cfg.slot_bytes);
    assign used_prod   = fspa_pkg::PROD_USED_W'(used_cnt) * fspa_pkg::PROD_USED_W'(cfg.obj_bytes);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_move) begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_offset_reg <= offset_prod[fspa_pkg::OFS_W-1:0];
            out_free_reg   <= res_free_reg;
            out_used_reg   <= used_prod[fspa_pkg::USED_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'b0, out_used_reg, out_free_reg, out_offset_reg, out_index_reg};

endmodule

// ----- src/fixed_slot_pool_allocator_core.sv -----
// Top level of the fixed slot pool allocator: config registers and part wiring.
`timescale 1ns / 1ps

// Grants and takes back indices of 1024 equal slots. Freed slots go on a LIFO
// stack kept in a 1024-entry link memory; slots untouched since the last pool
// reset are granted from the highest index down. Each request gives exactly
// one response on the m_ side. The back part handles one request per cycle
// while the m_ side does not stall, except an allocate served from the freed
// stack, which also passes the BK_LINK state because the new stack head comes
// from a registered link memory read. A response shows on m_tvalid after the
// request passes the input register, the queue and the state update, and the
// product register drives the m_ side. The two-entry queue lets the front
// keep taking requests while the back or the output stalls. No clearing
// pass is needed after reset. Write object_bytes and align_log2 only while no
// request is in flight.

`include "assert_macros.svh"

module fixed_slot_pool_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_bytes, req_align_log2, free_slot, zero pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // slot_index, slot_offset, free_cnt, used_bytes, pad
    output logic [1:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic {
        REG_OBJECT_BYTES = 1'b0,
        REG_ALIGN_LOG2   = 1'b1
    } reg_idx_t;

    logic [fspa_pkg::OBJ_W-1:0]   obj_reg;
    logic [fspa_pkg::ALIGN_W-1:0] align_reg;
    reg_idx_t                     reg_idx;
    logic                         cfg_wr;
    fspa_pkg::cfg_t               cfg;

    logic                         push_valid;
    logic                         push_ready;
    fspa_pkg::op_t                push_op;
    logic                         pop_valid;
    logic                         pop_ready;
    fspa_pkg::op_t                pop_op;

    logic [fspa_pkg::IDX_W-1:0]   mon_index;
    logic [fspa_pkg::OFS_W-1:0]   mon_offset;
    logic [fspa_pkg::CNT_W-1:0]   mon_free;
    logic [fspa_pkg::USED_W-1:0]  mon_used;
    logic                         mon_pool_reset;
    logic                         mon_all_free;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obj_reg   <= fspa_pkg::OBJ_W'(fspa_pkg::OBJ_MIN);
            align_reg <= fspa_pkg::ALIGN_W'(4);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_OBJECT_BYTES: obj_reg   <= pwdata[fspa_pkg::OBJ_W-1:0];
                REG_ALIGN_LOG2:   align_reg <= pwdata[fspa_pkg::ALIGN_W-1:0];
                default:          obj_reg   <= obj_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OBJECT_BYTES: prdata = 32'(obj_reg);
            REG_ALIGN_LOG2:   prdata = 32'(align_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        cfg.obj_bytes  = fspa_pkg::eff_object(obj_reg);
        cfg.align_log2 = fspa_pkg::eff_align(align_reg);
        cfg.slot_bytes = fspa_pkg::aligned_size(cfg.obj_bytes, cfg.align_log2);
    end

    fspa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    fspa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    fspa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assign mon_index      = m_tdata[9:0];
    assign mon_offset     = m_tdata[32:10];
    assign mon_free       = m_tdata[43:33];
    assign mon_used       = m_tdata[66:44];
    assign mon_pool_reset = m_tvalid && m_tuser == fspa_pkg::ST_RESET_DONE;
    assign mon_all_free   = mon_free == fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS);

    `ASSERT_NEXT(a_queue_fill, push_valid && push_ready && !pop_valid, pop_valid)
    `ASSERT_HOLDS(a_reset_done, mon_pool_reset, mon_all_free && mon_used == '0)
    `ASSERT_HOLDS(a_no_grant, m_tvalid && m_tuser != fspa_pkg::ST_OK, mon_index == '0 && mon_offset == '0)
    `ASSERT_HOLDS(a_count_range, m_tvalid, mon_free <= fspa_pkg::CNT_W'(fspa_pkg::POOL_SLOTS))

endmodule
